### sv/ranked_array_list_defines.svh
// Assertion macros shared by the list's modules.
// Each macro expects the module to have i_clk and i_rst_n in scope.
`ifndef RANKED_ARRAY_LIST_DEFINES_SVH
`define RANKED_ARRAY_LIST_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define RAL_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define RAL_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/ral_pkg.sv
package ral_pkg;

    // Fixed port widths of the request and result fields.
    localparam int unsigned OP_W     = 3;
    localparam int unsigned POS_W    = 6;
    localparam int unsigned ENTRY_W  = 64;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned COUNT_W  = 6;

    // Request operation codes.
    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 3'd0,
        OP_REMOVE = 3'd1,
        OP_GET    = 3'd2,
        OP_SET    = 3'd3,
        OP_CLEAR  = 3'd4
    } t_op;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_BAD_POS = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    // Work that the back end has to do for a classified request.
    typedef enum logic [2:0] {
        K_NONE,
        K_ADD,
        K_REMOVE,
        K_GET,
        K_SET
    } t_kind;

    // Control part of a classified request.
    typedef struct packed {
        t_kind   kind;
        t_status status;
    } t_ctrl;

    // Back end sequencer states.
    typedef enum logic [1:0] {
        B_IDLE,
        B_FETCH,
        B_SHIFT,
        B_PLACE
    } t_bstate;

endpackage

### sv/ral_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data.
module ral_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/ral_queue.sv
`include "ranked_array_list_defines.svh"

// Two-entry FIFO between the front end and the back end.
module ral_queue #(
    parameter int unsigned WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_push_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_valid,
    output logic             o_full
);

    logic [WIDTH-1:0] r_slot [2];
    logic             r_wptr;
    logic             r_rptr;
    logic [1:0]       r_fill;
    logic             n_wptr;
    logic             n_rptr;
    logic [1:0]       n_fill;

    // Pointer and fill bookkeeping.
    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_fill = r_fill;
        if (i_push) begin
            n_wptr = ~r_wptr;
        end
        if (i_pop) begin
            n_rptr = ~r_rptr;
        end
        if (i_push && !i_pop) begin
            n_fill = r_fill + 2'd1;
        end else if (i_pop && !i_push) begin
            n_fill = r_fill - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_fill <= n_fill;
        end
    end

    // Storage slots carry no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_push_data;
        end
    end

    assign o_data  = r_slot[r_rptr];
    assign o_valid = (r_fill != 2'd0);
    assign o_full  = (r_fill == 2'd2);

    `RAL_CHECK(a_no_overflow, i_push, !o_full, "request pushed into a full queue")
    `RAL_CHECK(a_no_underflow, i_pop, o_valid, "request popped from an empty queue")

endmodule

### sv/ral_front.sv
`include "ranked_array_list_defines.svh"

// Front end: accepts requests, owns the entry count and classifies each request.
module ral_front #(
    parameter int unsigned CAPACITY    = 32,
    parameter int unsigned ENTRY_WIDTH = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [ral_pkg::OP_W-1:0]          i_operation,
    input  logic [ral_pkg::POS_W-1:0]         i_position,
    input  logic [ral_pkg::ENTRY_W-1:0]       i_entry_in,
    input  logic                              i_full,
    output logic                              o_busy,
    output logic                              o_push,
    output ral_pkg::t_ctrl                    o_ctrl,
    output logic [$clog2(CAPACITY)-1:0]       o_pos,
    output logic [$clog2(CAPACITY+1)-1:0]     o_moves,
    output logic [$clog2(CAPACITY+1)-1:0]     o_count,
    output logic [ENTRY_WIDTH-1:0]            o_data
);

    localparam int unsigned AW   = $clog2(CAPACITY);
    localparam int unsigned CW   = $clog2(CAPACITY + 1);
    localparam int unsigned CMPW = (CW > ral_pkg::POS_W) ? CW : ral_pkg::POS_W;

    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;
    logic [CMPW-1:0] pos_ext;
    logic [CMPW-1:0] cnt_ext;
    logic            accept;

    assign accept  = i_start && !i_full;
    assign pos_ext = CMPW'(i_position);
    assign cnt_ext = CMPW'(r_count);

    // Classification against the count as it stands before this request.
    always_comb begin
        o_ctrl.kind   = ral_pkg::K_NONE;
        o_ctrl.status = ral_pkg::ST_OK;
        o_moves       = '0;
        n_count       = r_count;
        case (i_operation)
            ral_pkg::OP_ADD: begin
                if (pos_ext > cnt_ext) begin
                    o_ctrl.status = ral_pkg::ST_BAD_POS;
                end else if (r_count == CW'(CAPACITY)) begin
                    o_ctrl.status = ral_pkg::ST_FULL;
                end else begin
                    o_ctrl.kind = ral_pkg::K_ADD;
                    o_moves     = CW'(cnt_ext - pos_ext);
                    n_count     = r_count + CW'(1);
                end
            end
            ral_pkg::OP_REMOVE, ral_pkg::OP_GET, ral_pkg::OP_SET: begin
                if (pos_ext >= cnt_ext) begin
                    o_ctrl.status = ral_pkg::ST_BAD_POS;
                end else if (i_operation == ral_pkg::OP_REMOVE) begin
                    o_ctrl.kind = ral_pkg::K_REMOVE;
                    o_moves     = CW'(cnt_ext - pos_ext - CMPW'(1));
                    n_count     = r_count - CW'(1);
                end else if (i_operation == ral_pkg::OP_GET) begin
                    o_ctrl.kind = ral_pkg::K_GET;
                end else begin
                    o_ctrl.kind = ral_pkg::K_SET;
                end
            end
            ral_pkg::OP_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (accept) begin
            r_count <= n_count;
        end
    end

    assign o_busy  = i_full;
    assign o_push  = accept;
    assign o_pos   = AW'(i_position);
    assign o_count = n_count;
    assign o_data  = i_entry_in[ENTRY_WIDTH-1:0];

    `RAL_CHECK(a_count_bound, 1'b1, r_count <= CW'(CAPACITY), "entry count above capacity")

endmodule

### sv/ral_back.sv
`include "ranked_array_list_defines.svh"

// Back end: carries out classified requests on the entry RAM and issues results.
module ral_back #(
    parameter int unsigned CAPACITY    = 32,
    parameter int unsigned ENTRY_WIDTH = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  ral_pkg::t_ctrl                i_ctrl,
    input  logic [$clog2(CAPACITY)-1:0]   i_pos,
    input  logic [$clog2(CAPACITY+1)-1:0] i_moves,
    input  logic [$clog2(CAPACITY+1)-1:0] i_count,
    input  logic [ENTRY_WIDTH-1:0]        i_data,
    output logic                          o_pop,
    output logic                          o_strobe,
    output ral_pkg::t_status              o_status,
    output logic [ENTRY_WIDTH-1:0]        o_entry,
    output logic [$clog2(CAPACITY+1)-1:0] o_count
);

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);

    ral_pkg::t_bstate r_state, n_state;
    ral_pkg::t_kind   r_kind, n_kind;
    ral_pkg::t_status r_status, n_status;
    logic [AW-1:0]    r_pos, n_pos;
    logic [AW-1:0]    r_src, n_src;
    logic [AW-1:0]    r_dst, n_dst;
    logic [CW-1:0]    r_left, n_left;
    logic [CW-1:0]    r_count, n_count;
    logic [ENTRY_WIDTH-1:0] r_data, n_data;
    logic [ENTRY_WIDTH-1:0] r_result, n_result;

    logic                   r_strobe, n_strobe;
    ral_pkg::t_status       r_out_status, n_out_status;
    logic [ENTRY_WIDTH-1:0] r_out_entry, n_out_entry;
    logic [CW-1:0]          r_out_count, n_out_count;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [ENTRY_WIDTH-1:0] ram_wdata;
    logic                   ram_re;
    logic [AW-1:0]          ram_raddr;
    logic [ENTRY_WIDTH-1:0] ram_rdata;
    logic [CW-1:0]          pos_plus_moves;

    // Entry storage.
    ral_ram #(
        .WIDTH (ENTRY_WIDTH),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // For an add, the old count equals the position plus the number of moves.
    assign pos_plus_moves = CW'(i_pos) + i_moves;

    // Sequencer: next state, RAM accesses and result issue.
    always_comb begin
        n_state      = r_state;
        n_kind       = r_kind;
        n_status     = r_status;
        n_pos        = r_pos;
        n_src        = r_src;
        n_dst        = r_dst;
        n_left       = r_left;
        n_count      = r_count;
        n_data       = r_data;
        n_result     = r_result;
        n_strobe     = 1'b0;
        n_out_status = r_out_status;
        n_out_entry  = r_out_entry;
        n_out_count  = r_out_count;
        ram_we       = 1'b0;
        ram_waddr    = r_dst;
        ram_wdata    = ram_rdata;
        ram_re       = 1'b0;
        ram_raddr    = r_src;
        o_pop        = 1'b0;
        case (r_state)
            ral_pkg::B_IDLE: begin
                if (i_valid) begin
                    o_pop    = 1'b1;
                    n_kind   = i_ctrl.kind;
                    n_status = i_ctrl.status;
                    n_pos    = i_pos;
                    n_left   = i_moves;
                    n_count  = i_count;
                    n_data   = i_data;
                    case (i_ctrl.kind)
                        ral_pkg::K_GET, ral_pkg::K_SET, ral_pkg::K_REMOVE: begin
                            ram_re    = 1'b1;
                            ram_raddr = i_pos;
                            n_state   = ral_pkg::B_FETCH;
                        end
                        ral_pkg::K_ADD: begin
                            if (i_moves == '0) begin
                                // Append at the end: no entries move.
                                ram_we       = 1'b1;
                                ram_waddr    = i_pos;
                                ram_wdata    = i_data;
                                n_strobe     = 1'b1;
                                n_out_status = i_ctrl.status;
                                n_out_entry  = '0;
                                n_out_count  = i_count;
                            end else begin
                                // Shift from the top entry down toward the position.
                                ram_re    = 1'b1;
                                ram_raddr = AW'(pos_plus_moves - CW'(1));
                                n_src     = AW'(pos_plus_moves - CW'(1));
                                n_dst     = AW'(pos_plus_moves);
                                n_state   = ral_pkg::B_SHIFT;
                            end
                        end
                        default: begin
                            // Failed, clear and unknown requests touch no entry.
                            n_strobe     = 1'b1;
                            n_out_status = i_ctrl.status;
                            n_out_entry  = '0;
                            n_out_count  = i_count;
                        end
                    endcase
                end
            end
            ral_pkg::B_FETCH: begin
                case (r_kind)
                    ral_pkg::K_SET: begin
                        ram_we       = 1'b1;
                        ram_waddr    = r_pos;
                        ram_wdata    = r_data;
                        n_strobe     = 1'b1;
                        n_out_status = r_status;
                        n_out_entry  = ram_rdata;
                        n_out_count  = r_count;
                        n_state      = ral_pkg::B_IDLE;
                    end
                    ral_pkg::K_REMOVE: begin
                        n_result = ram_rdata;
                        if (r_left == '0) begin
                            n_strobe     = 1'b1;
                            n_out_status = r_status;
                            n_out_entry  = ram_rdata;
                            n_out_count  = r_count;
                            n_state      = ral_pkg::B_IDLE;
                        end else begin
                            // Close the gap, starting just above the position.
                            ram_re    = 1'b1;
                            ram_raddr = r_pos + AW'(1);
                            n_src     = r_pos + AW'(1);
                            n_dst     = r_pos;
                            n_state   = ral_pkg::B_SHIFT;
                        end
                    end
                    default: begin
                        n_strobe     = 1'b1;
                        n_out_status = r_status;
                        n_out_entry  = ram_rdata;
                        n_out_count  = r_count;
                        n_state      = ral_pkg::B_IDLE;
                    end
                endcase
            end
            ral_pkg::B_SHIFT: begin
                // Write the entry read last cycle and, while moves remain, issue the next read.
                ram_we    = 1'b1;
                ram_waddr = r_dst;
                ram_wdata = ram_rdata;
                if (r_left == CW'(1)) begin
                    if (r_kind == ral_pkg::K_ADD) begin
                        n_state = ral_pkg::B_PLACE;
                    end else begin
                        n_strobe     = 1'b1;
                        n_out_status = r_status;
                        n_out_entry  = r_result;
                        n_out_count  = r_count;
                        n_state      = ral_pkg::B_IDLE;
                    end
                end else begin
                    n_left = r_left - CW'(1);
                    if (r_kind == ral_pkg::K_ADD) begin
                        n_src = r_src - AW'(1);
                        n_dst = r_dst - AW'(1);
                    end else begin
                        n_src = r_src + AW'(1);
                        n_dst = r_dst + AW'(1);
                    end
                    ram_re    = 1'b1;
                    ram_raddr = n_src;
                end
            end
            ral_pkg::B_PLACE: begin
                ram_we       = 1'b1;
                ram_waddr    = r_pos;
                ram_wdata    = r_data;
                n_strobe     = 1'b1;
                n_out_status = r_status;
                n_out_entry  = '0;
                n_out_count  = r_count;
                n_state      = ral_pkg::B_IDLE;
            end
            default: begin
                n_state = ral_pkg::B_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ral_pkg::B_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    // Request and result payload.
    always_ff @(posedge i_clk) begin
        r_kind       <= n_kind;
        r_status     <= n_status;
        r_pos        <= n_pos;
        r_src        <= n_src;
        r_dst        <= n_dst;
        r_left       <= n_left;
        r_count      <= n_count;
        r_data       <= n_data;
        r_result     <= n_result;
        r_out_status <= n_out_status;
        r_out_entry  <= n_out_entry;
        r_out_count  <= n_out_count;
    end

    assign o_strobe = r_strobe;
    assign o_status = r_out_status;
    assign o_entry  = r_out_entry;
    assign o_count  = r_out_count;

    `RAL_CHECK(a_shift_left, r_state == ral_pkg::B_SHIFT, r_left != '0, "shift with no moves left")
    `RAL_CHECK_NEXT(a_fetch_result,
        r_state == ral_pkg::B_FETCH && (r_kind == ral_pkg::K_GET || r_kind == ral_pkg::K_SET),
        r_strobe && r_state == ral_pkg::B_IDLE, "get or set gave no result after its read")
    `RAL_CHECK_NEXT(a_place_result, r_state == ral_pkg::B_PLACE,
        r_strobe && r_state == ral_pkg::B_IDLE, "add gave no result after placing its entry")

endmodule

### sv/ranked_array_list.sv
// Channel   Direction  Handshake                 Fields
// request   in         start high, busy low      i_operation, i_position, i_entry_in
// result    out        o_strobe, one cycle       o_status, o_entry_out, o_list_count
//
// Once the back end takes a request from the queue, a request that touches no entry or
// appends at the end has its result strobed without a RAM read; get and set first read
// the entry, add first shifts the entries from position p to the end of n entries up by one,
// and remove first shifts those above p down. The RAM moves one entry per cycle.
// A two-entry queue takes requests while the back end works; busy is high when it is full.
// Reset is synchronous and active low; it empties the list and the queue.
// The receiver cannot stall: each result is valid for exactly one cycle.
module ranked_array_list #(
    parameter int unsigned CAPACITY    = 32,
    parameter int unsigned ENTRY_WIDTH = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [ral_pkg::OP_W-1:0]        i_operation,
    input  logic [ral_pkg::POS_W-1:0]       i_position,
    input  logic [ral_pkg::ENTRY_W-1:0]     i_entry_in,
    output logic                            o_strobe,
    output logic [ral_pkg::STATUS_W-1:0]    o_status,
    output logic [ral_pkg::ENTRY_W-1:0]     o_entry_out,
    output logic [ral_pkg::COUNT_W-1:0]     o_list_count
);

    localparam int unsigned AW    = $clog2(CAPACITY);
    localparam int unsigned CW    = $clog2(CAPACITY + 1);
    localparam int unsigned CTW   = $bits(ral_pkg::t_ctrl);
    localparam int unsigned QW    = CTW + CW + CW + AW + ENTRY_WIDTH;
    localparam int unsigned OEW   = ral_pkg::ENTRY_W;
    localparam int unsigned OCW   = ral_pkg::COUNT_W;

    logic                   f_push;
    ral_pkg::t_ctrl         f_ctrl;
    logic [AW-1:0]          f_pos;
    logic [CW-1:0]          f_moves;
    logic [CW-1:0]          f_count;
    logic [ENTRY_WIDTH-1:0] f_data;

    logic [QW-1:0]          q_in;
    logic [QW-1:0]          q_out;
    logic                   q_valid;
    logic                   q_full;

    ral_pkg::t_ctrl         b_ctrl;
    logic [AW-1:0]          b_pos;
    logic [CW-1:0]          b_moves;
    logic [CW-1:0]          b_count;
    logic [ENTRY_WIDTH-1:0] b_data;
    logic                   b_pop;
    ral_pkg::t_status       b_status;
    logic [ENTRY_WIDTH-1:0] b_entry;
    logic [CW-1:0]          b_out_count;

    // Request intake and classification.
    ral_front #(
        .CAPACITY    (CAPACITY),
        .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_operation (i_operation),
        .i_position  (i_position),
        .i_entry_in  (i_entry_in),
        .i_full      (q_full),
        .o_busy      (busy),
        .o_push      (f_push),
        .o_ctrl      (f_ctrl),
        .o_pos       (f_pos),
        .o_moves     (f_moves),
        .o_count     (f_count),
        .o_data      (f_data)
    );

    // Classified requests waiting for the back end.
    assign q_in = {f_ctrl, f_count, f_moves, f_pos, f_data};

    ral_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (f_push),
        .i_push_data (q_in),
        .i_pop       (b_pop),
        .o_data      (q_out),
        .o_valid     (q_valid),
        .o_full      (q_full)
    );

    assign {b_ctrl, b_count, b_moves, b_pos, b_data} = q_out;

    // Execution on the entry RAM.
    ral_back #(
        .CAPACITY    (CAPACITY),
        .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_ctrl   (b_ctrl),
        .i_pos    (b_pos),
        .i_moves  (b_moves),
        .i_count  (b_count),
        .i_data   (b_data),
        .o_pop    (b_pop),
        .o_strobe (o_strobe),
        .o_status (b_status),
        .o_entry  (b_entry),
        .o_count  (b_out_count)
    );

    // Results at the fixed port widths.
    assign o_status     = b_status;
    assign o_entry_out  = OEW'(b_entry);
    assign o_list_count = OCW'(b_out_count);

endmodule

### verif/ranked_array_list_test.sv
`timescale 1ns / 1ps

module ranked_array_list_test;

    localparam int unsigned LIST_CAP    = 32;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned RANDOM_REQS = 850;
    localparam int unsigned DRAIN_WAIT  = 64;

    // One result of the list as the receiver sees it.
    typedef struct packed {
        logic [ral_pkg::STATUS_W-1:0] status;
        logic [ral_pkg::ENTRY_W-1:0]  entry;
        logic [ral_pkg::COUNT_W-1:0]  count;
    } t_list_result;

    // Shadow copy of the list: predicts each result and checks it in order.
    class t_list_tracker;
        logic [ral_pkg::ENTRY_W-1:0] store [LIST_CAP];
        int unsigned                 count;
        t_list_result                expected_results [$];
        int unsigned                 errors;

        function new();
            foreach (store[i]) store[i] = '0;
            count  = 0;
            errors = 0;
        endfunction

        function int unsigned pending();
            return expected_results.size();
        endfunction

        // Apply an accepted request to the shadow list and queue its result.
        function void accept_request(logic [ral_pkg::OP_W-1:0] op,
                                     logic [ral_pkg::POS_W-1:0] pos,
                                     logic [ral_pkg::ENTRY_W-1:0] data);
            t_list_result res;
            int unsigned  i;
            res.status = ral_pkg::ST_OK;
            res.entry  = '0;
            case (op)
                ral_pkg::OP_ADD: begin
                    if (pos > count) begin
                        res.status = ral_pkg::ST_BAD_POS;
                    end else if (count == LIST_CAP) begin
                        res.status = ral_pkg::ST_FULL;
                    end else begin
                        for (i = count; i > pos; i--) store[i] = store[i-1];
                        store[pos] = data;
                        count++;
                    end
                end
                ral_pkg::OP_REMOVE, ral_pkg::OP_GET, ral_pkg::OP_SET: begin
                    if (pos >= count) begin
                        res.status = ral_pkg::ST_BAD_POS;
                    end else begin
                        res.entry = store[pos];
                        if (op == ral_pkg::OP_REMOVE) begin
                            for (i = pos; i + 1 < count; i++) store[i] = store[i+1];
                            count--;
                        end else if (op == ral_pkg::OP_SET) begin
                            store[pos] = data;
                        end
                    end
                end
                ral_pkg::OP_CLEAR: begin
                    count = 0;
                end
                default: ;
            endcase
            res.count = count[ral_pkg::COUNT_W-1:0];
            expected_results.push_back(res);
        endfunction

        // Compare one result with the oldest prediction, field by field.
        function void check_result(logic [ral_pkg::STATUS_W-1:0] status,
                                   logic [ral_pkg::ENTRY_W-1:0] entry,
                                   logic [ral_pkg::COUNT_W-1:0] cnt);
            t_list_result exp_res;
            if (expected_results.size() == 0) begin
                $error("result with no request outstanding: status %0d entry %h count %0d",
                       status, entry, cnt);
                errors++;
                return;
            end
            exp_res = expected_results.pop_front();
            if (status !== exp_res.status) begin
                $error("status mismatch: expected %0d, actual %0d", exp_res.status, status);
                errors++;
            end
            if (entry !== exp_res.entry) begin
                $error("entry_out mismatch: expected %h, actual %h", exp_res.entry, entry);
                errors++;
            end
            if (cnt !== exp_res.count) begin
                $error("list_count mismatch: expected %0d, actual %0d", exp_res.count, cnt);
                errors++;
            end
        endfunction
    endclass

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         start;
    logic                         busy;
    logic [ral_pkg::OP_W-1:0]     i_operation;
    logic [ral_pkg::POS_W-1:0]    i_position;
    logic [ral_pkg::ENTRY_W-1:0]  i_entry_in;
    logic                         o_strobe;
    logic [ral_pkg::STATUS_W-1:0] o_status;
    logic [ral_pkg::ENTRY_W-1:0]  o_entry_out;
    logic [ral_pkg::COUNT_W-1:0]  o_list_count;

    t_list_tracker tracker = new();
    int unsigned   cycles  = 0;
    bit            sender_idles;

    ranked_array_list #(
        .CAPACITY    (LIST_CAP),
        .ENTRY_WIDTH (ral_pkg::ENTRY_W)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_operation  (i_operation),
        .i_position   (i_position),
        .i_entry_in   (i_entry_in),
        .o_strobe     (o_strobe),
        .o_status     (o_status),
        .o_entry_out  (o_entry_out),
        .o_list_count (o_list_count)
    );

    // Clock with a 4 ns period.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Hard stop in case the block hangs.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Every strobed result is checked at the edge that ends its cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            tracker.check_result(o_status, o_entry_out, o_list_count);
        end
    end

    // Present one request from a falling edge, hold it until accepted, then idle a while if the sender idles.
    task automatic send_request(logic [ral_pkg::OP_W-1:0] op, logic [ral_pkg::POS_W-1:0] pos,
                                logic [ral_pkg::ENTRY_W-1:0] data);
        int unsigned gap;
        i_operation = op;
        i_position  = pos;
        i_entry_in  = data;
        start       = 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        tracker.accept_request(op, pos, data);
        @(negedge i_clk);
        gap = sender_idles ? $urandom_range(0, 16) : 0;
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // Entry data with the all-zero, all-one and single-bit patterns mixed in.
    function automatic logic [ral_pkg::ENTRY_W-1:0] pick_entry();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return 64'd1 << $urandom_range(0, 63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Mostly a legal rank with the ends favored; otherwise one past the end or beyond.
    function automatic logic [ral_pkg::POS_W-1:0] pick_position(int valid_hi);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (valid_hi < 0 || r < 12) return ral_pkg::POS_W'($urandom_range(valid_hi + 1, 63));
        if (r < 22) return '0;
        if (r < 32) return ral_pkg::POS_W'(valid_hi);
        return ral_pkg::POS_W'($urandom_range(0, valid_hi));
    endfunction

    // Edge cases on an empty, short and cleared list.
    task automatic directed_requests();
        send_request(ral_pkg::OP_GET, 0, '0);
        send_request(ral_pkg::OP_REMOVE, 0, '0);
        send_request(ral_pkg::OP_SET, 0, '1);
        send_request(ral_pkg::OP_ADD, 1, '1);
        send_request(ral_pkg::OP_ADD, 63, '1);
        send_request(ral_pkg::OP_ADD, 0, '1);
        send_request(ral_pkg::OP_ADD, 1, '0);
        send_request(ral_pkg::OP_ADD, 0, 64'h0123_4567_89AB_CDEF);
        send_request(ral_pkg::OP_ADD, 3, 64'h8000_0000_0000_0001);
        send_request(ral_pkg::OP_GET, 0, '0);
        send_request(ral_pkg::OP_GET, 3, '0);
        send_request(ral_pkg::OP_SET, 1, 64'h5555_5555_5555_5555);
        send_request(ral_pkg::OP_GET, 1, '0);
        send_request(ral_pkg::OP_GET, 4, '0);
        send_request(ral_pkg::OP_SET, 63, '1);
        send_request(ral_pkg::OP_REMOVE, 1, '0);
        send_request(ral_pkg::OP_REMOVE, 2, '0);
        send_request(3'd5, 63, '1);
        send_request(3'd6, 0, '0);
        send_request(3'd7, 32, '1);
        send_request(ral_pkg::OP_CLEAR, 0, '0);
        send_request(ral_pkg::OP_GET, 0, '0);
        send_request(ral_pkg::OP_ADD, 0, 64'hAAAA_AAAA_AAAA_AAAA);
        send_request(ral_pkg::OP_REMOVE, 0, '0);
    endtask

    // Phases that grow, shrink or churn the list, so it often fills up and drains.
    task automatic random_requests();
        int unsigned sent;
        int unsigned phase_len;
        int unsigned mode;
        int unsigned r;
        int unsigned add_lim;
        int unsigned rem_lim;
        int unsigned get_lim;
        int unsigned set_lim;
        int unsigned clr_lim;
        logic [ral_pkg::OP_W-1:0] op;
        sent = 0;
        while (sent < RANDOM_REQS) begin
            mode         = $urandom_range(0, 2);
            phase_len    = $urandom_range(30, 90);
            sender_idles = ($urandom_range(0, 3) != 0);
            case (mode)
                0: begin add_lim = 65; rem_lim = 75; get_lim = 85; set_lim = 95; clr_lim = 96; end
                1: begin add_lim = 15; rem_lim = 70; get_lim = 82; set_lim = 94; clr_lim = 96; end
                default: begin
                    add_lim = 35; rem_lim = 65; get_lim = 80; set_lim = 95; clr_lim = 97;
                end
            endcase
            repeat (phase_len) begin
                r = $urandom_range(0, 99);
                if (r < add_lim) op = ral_pkg::OP_ADD;
                else if (r < rem_lim) op = ral_pkg::OP_REMOVE;
                else if (r < get_lim) op = ral_pkg::OP_GET;
                else if (r < set_lim) op = ral_pkg::OP_SET;
                else if (r < clr_lim) op = ral_pkg::OP_CLEAR;
                else op = ral_pkg::OP_W'($urandom_range(5, 7));
                if (op == ral_pkg::OP_ADD) begin
                    send_request(op, pick_position(tracker.count), pick_entry());
                end else begin
                    send_request(op, pick_position(int'(tracker.count) - 1), pick_entry());
                end
                sent++;
            end
        end
    endtask

    // Reset, stimulus, drain and final verdict.
    initial begin
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_operation  = '0;
        i_position   = '0;
        i_entry_in   = '0;
        sender_idles = 1'b1;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        directed_requests();
        random_requests();
        start = 1'b0;

        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
